// ===== rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;
  localparam int ArenaBytes = 4096;
  localparam int HeaderBytes = 16;
  localparam int LinkW = 13;
  localparam int AddrW = 12;
  localparam logic [LinkW-1:0] LinkNone = 13'd4096;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic        mode;
    logic [12:0] request_size;
    logic [11:0] block_address;
  } req_t;

  typedef struct packed {
    logic [11:0] granted_address;
    logic        status;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/best_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Best-fit free-list allocator over a byte arena with an address-ordered
// free list and coalescing on free.
// Channels: a request (allocate or free) is a transfer at a clock edge with
// start high and busy low. The single result appears on result for one
// cycle with done high; the receiver cannot hold it off, so it must take it.
// The arena size register is written through cfg_we/cfg_data while idle;
// a write rebuilds the arena as one free block, which keeps busy high until
// the header of that block is written.
// Walk: each free-list block is visited with a header read, then a decide
// step. An allocate walks the list for the best fit and stops early on an
// exact fit; a free walks to its place, links the block in, then walks the
// whole list again to merge neighbours. The header memory, with one read
// port, sets the pace.
// Busy stays high until done is raised and is low again in the cycle that carries done; one request at a time.
// Reset: the arena is one free block of 4096 bytes, written in the first
// cycle after reset while busy is high; no clearing pass is run.
module best_fit_allocator (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire bfa_pkg::req_t  req,
  output logic                busy,
  output logic                done,
  output bfa_pkg::rsp_t       result,
  input  wire                 cfg_we,
  input  wire [12:0]          cfg_data
);
  import bfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_AEV, S_AFIN, S_AFIN2, S_AUNL, S_ALNK, S_FRD, S_FEV,
    S_FINS, S_FLNK, S_CRD, S_CEV, S_CMRG, S_RESP
  } state_t;

  // Header memory: link and size per node address, one read port.
  logic [LinkW-1:0] mem_link [ArenaBytes];
  logic [AddrW-1:0] mem_size [ArenaBytes];
  logic [AddrW-1:0] rd_addr;
  logic [LinkW-1:0] rd_link;
  logic [AddrW-1:0] rd_size;
  logic             wr_en;
  logic             wr_size_en;
  logic [AddrW-1:0] wr_addr;
  logic [LinkW-1:0] wr_link;
  logic [AddrW-1:0] wr_size;

  always_ff @(posedge clk) begin
    if (wr_en) mem_link[wr_addr] <= wr_link;
    if (wr_size_en) mem_size[wr_addr] <= wr_size;
    rd_link <= mem_link[rd_addr];
    rd_size <= mem_size[rd_addr];
  end

  state_t           state;
  logic [12:0]      arena_size;
  logic [LinkW-1:0] free_head;
  logic             init_pend;
  logic [LinkW-1:0] cur, prev, best, best_pred;
  logic [12:0]      size;
  logic [12:0]      best_len;
  logic             best_ok;
  logic [AddrW-1:0] blk;
  logic [12:0]      steps;
  logic [LinkW-1:0] best_link;
  logic [AddrW-1:0] prev_size;

  // Adders: node end address and split arithmetic.
  logic [13:0] prev_end;
  logic [13:0] nb;
  logic [12:0] remain;
  logic        split;
  assign prev_end = {1'b0, prev} + 14'(HeaderBytes) + {2'b0, prev_size};
  assign nb = {1'b0, best} + 14'(HeaderBytes) + {1'b0, size};
  assign remain = best_len - size;
  assign split = best_ok && (best_len > size) && (remain > 13'(HeaderBytes)) &&
                 !nb[13] && !nb[12];

  assign busy = (state != S_IDLE) || init_pend;

  // An allocate larger than the arena fails at once.
  logic too_large;
  assign too_large = (req.mode == MODE_ALLOC) && (req.request_size > arena_size);

  // Clamped configuration value.
  logic [12:0] cfg_clamped;
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < 13'(HeaderBytes + 1)) cfg_clamped = 13'(HeaderBytes + 1);
    if (cfg_data > 13'(ArenaBytes)) cfg_clamped = 13'(ArenaBytes);
  end

  // Memory port selection.
  always_comb begin
    wr_en = 1'b0;
    wr_size_en = 1'b0;
    wr_addr = '0;
    wr_link = LinkNone;
    wr_size = '0;
    rd_addr = cur[AddrW-1:0];
    if (init_pend && state == S_IDLE) begin
      wr_en = 1'b1;
      wr_size_en = 1'b1;
      wr_size = AddrW'(arena_size - 13'(HeaderBytes));
    end
    unique case (state)
      S_AFIN: begin
        rd_addr = best[AddrW-1:0];
      end
      S_AFIN2: begin
        // The remainder block takes over the original link of best.
        if (split) begin
          wr_en = 1'b1;
          wr_size_en = 1'b1;
          wr_addr = nb[AddrW-1:0];
          wr_link = rd_link;
          wr_size = AddrW'(remain - 13'(HeaderBytes));
        end
      end
      S_AUNL: begin
        if (split) begin
          wr_en = 1'b1;
          wr_size_en = 1'b1;
          wr_addr = best[AddrW-1:0];
          wr_link = {1'b0, nb[AddrW-1:0]};
          wr_size = size[AddrW-1:0];
        end
      end
      S_ALNK: begin
        if (!(best == free_head || best_pred[12])) begin
          wr_en = 1'b1;
          wr_addr = best_pred[AddrW-1:0];
          wr_link = best_link;
        end
      end
      S_FINS: begin
        wr_en = 1'b1;
        wr_addr = blk;
        wr_link = cur[12] ? LinkNone : cur;
      end
      S_FLNK: begin
        wr_en = 1'b1;
        wr_addr = prev[AddrW-1:0];
        wr_link = {1'b0, blk};
      end
      S_CMRG: begin
        wr_en = 1'b1;
        wr_size_en = 1'b1;
        wr_addr = prev[AddrW-1:0];
        wr_link = rd_link;
        wr_size = prev_size + rd_size + AddrW'(HeaderBytes);
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      arena_size <= 13'(ArenaBytes);
      free_head <= '0;
      init_pend <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= (state == S_RESP);
      unique case (state)
        S_IDLE: begin
          if (cfg_we) begin
            arena_size <= cfg_clamped;
            free_head <= '0;
            init_pend <= 1'b1;
          end else if (init_pend) begin
            init_pend <= 1'b0;
          end else if (start) begin
            result <= {12'd0, too_large};
            cur <= free_head;
            prev <= LinkNone;
            steps <= '0;
            size <= req.request_size;
            blk <= req.block_address - AddrW'(HeaderBytes);
            best <= LinkNone;
            best_ok <= 1'b0;
            best_pred <= LinkNone;
            best_len <= '1;
            if (req.mode == MODE_ALLOC) begin
              if (too_large) begin
                state <= S_RESP;
              end else begin
                state <= S_ARD;
              end
            end else begin
              if ({1'b0, req.block_address} < 13'(HeaderBytes) ||
                  {1'b0, req.block_address} >= arena_size) begin
                state <= S_RESP;
              end else begin
                state <= S_FRD;
              end
            end
          end
        end
        // Allocate walk: read header at cur, then evaluate.
        S_ARD: begin
          if (cur[12] || steps[12]) state <= S_AFIN;
          else state <= S_AEV;
        end
        S_AEV: begin
          steps <= steps + 13'd1;
          prev <= cur;
          cur <= rd_link;
          state <= S_ARD;
          if ({1'b0, rd_size} >= size && {1'b0, rd_size} < best_len) begin
            best_len <= {1'b0, rd_size};
            best <= cur;
            best_ok <= 1'b1;
            best_pred <= prev;
            if ({1'b0, rd_size} == size) state <= S_AFIN;
          end
        end
        S_AFIN: begin
          if (!best_ok) begin
            result.status <= 1'b1;
            state <= S_RESP;
          end else begin
            state <= S_AFIN2;
          end
        end
        S_AFIN2: begin
          // rd_link holds the original link of best.
          best_link <= split ? {1'b0, nb[AddrW-1:0]} : rd_link;
          state <= S_AUNL;
        end
        S_AUNL: begin
          state <= S_ALNK;
        end
        // Unlink best from the list and report its user offset.
        S_ALNK: begin
          if (best == free_head || best_pred[12]) free_head <= best_link;
          result.granted_address <= best[AddrW-1:0] + AddrW'(HeaderBytes);
          state <= S_RESP;
        end
        // Free walk: find insert point.
        S_FRD: begin
          if (cur[12] || steps[12]) state <= S_FINS;
          else state <= S_FEV;
        end
        S_FEV: begin
          steps <= steps + 13'd1;
          if (cur[AddrW-1:0] == blk) begin
            state <= S_RESP;
          end else if (cur[AddrW-1:0] > blk) begin
            state <= S_FINS;
          end else begin
            prev <= cur;
            cur <= rd_link;
            state <= S_FRD;
          end
        end
        S_FINS: begin
          if (prev[12]) begin
            free_head <= {1'b0, blk};
            cur <= {1'b0, blk};
            prev <= LinkNone;
            steps <= '0;
            state <= S_CRD;
          end else begin
            state <= S_FLNK;
          end
        end
        // The block before the insert point now links to the freed block.
        S_FLNK: begin
          cur <= free_head;
          prev <= LinkNone;
          steps <= '0;
          state <= S_CRD;
        end
        // Coalescing walk over the whole list.
        S_CRD: begin
          if (cur[12] || steps[12]) state <= S_RESP;
          else state <= S_CEV;
        end
        S_CEV: begin
          steps <= steps + 13'd1;
          if (!prev[12] && prev_end == {1'b0, cur}) begin
            state <= S_CMRG;
          end else begin
            prev <= cur;
            prev_size <= rd_size;
            cur <= rd_link;
            state <= S_CRD;
          end
        end
        S_CMRG: begin
          prev_size <= prev_size + rd_size + AddrW'(HeaderBytes);
          cur <= rd_link;
          state <= S_CRD;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
